// ===== rtl/core/flbi_pkg.sv =====
// ----------------------------------------------------------------------------
// flbi_pkg
// Shared types and constants of the log bucket index: the input and result
// words, function and status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package flbi_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned BYTES_W = 13;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;

  // register indexes of the configuration port
  localparam logic REG_BUCKET = 1'b0;
  localparam logic REG_NOTIFY = 1'b1;

  localparam logic [BYTES_W-1:0] BUCKET_RESET = 13'd4084;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 3'd0,
    FUNC_FIND    = 3'd1,
    FUNC_REMOVE  = 3'd2,
    FUNC_REORDER = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_TOO_LARGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  value_len;
    logic [MASK_W-1:0] hit_mask;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               is_eviction;
    logic [KEY_W-1:0]   key_out;
    logic [IDX_W-1:0]   entry_index;
    logic [LEN_W-1:0]   found_len;
    logic [CNT_W-1:0]   evictions;
    logic [BYTES_W-1:0] free_bytes;
    logic [CNT_W-1:0]   entry_count;
    logic               last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INSERT,
    ST_SCAN,
    ST_REM_FIN,
    ST_REORDER,
    ST_FINAL
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EVICT,
    CMD_APPEND,
    CMD_SCAN_NEXT,
    CMD_DROP,
    CMD_MOVE,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [3:0] {
    EMIT_NONE,
    EMIT_TOO_LARGE,
    EMIT_EVICT,
    EMIT_INSERT,
    EMIT_NOT_FOUND,
    EMIT_FOUND,
    EMIT_REM_EV,
    EMIT_REM_FIN,
    EMIT_PLAIN
  } emit_e;

  typedef struct packed {
    cmd_e  cmd;
    emit_e emit;
    logic  idle;
  } ctrl_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              too_large;
    logic              need_evict;
    logic              scan_end;
    logic              scan_match;
    logic              rem_zero;
    logic              hit_now;
    logic              out_free;
    logic              notify;
  } stat_t;

  // bytes left in the bucket, zero when the bucket has shrunk below use
  function automatic logic [BYTES_W-1:0] free_of(input logic [BYTES_W-1:0] used,
                                                 input logic [BYTES_W-1:0] bucket);
    logic [BYTES_W-1:0] res;
    res = (used >= bucket) ? '0 : bucket - used;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/flbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// flbi_ctrl
// Sequencer of the log bucket index: walks one word through dispatch,
// eviction, scan, removal and reorder steps and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module flbi_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  flbi_pkg::stat_t     stat_i,
  output flbi_pkg::ctrl_t     ctrl_o
);
  import flbi_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat_i.func)
          FUNC_INSERT:  state_d = ST_INSERT;
          FUNC_FIND:    state_d = ST_SCAN;
          FUNC_REMOVE:  state_d = ST_SCAN;
          FUNC_REORDER: state_d = ST_REORDER;
          default:      state_d = ST_FINAL;
        endcase
      end
      ST_INSERT: begin
        if (stat_i.too_large || !stat_i.need_evict) begin
          if (stat_i.out_free) state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_end) begin
          if (stat_i.out_free) state_d = ST_IDLE;
        end else if (stat_i.scan_match) begin
          if (stat_i.func == FUNC_FIND) begin
            if (stat_i.out_free) state_d = ST_IDLE;
          end else if (stat_i.out_free || !stat_i.notify) begin
            state_d = ST_REM_FIN;
          end
        end
      end
      ST_REM_FIN: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_REORDER: begin
        if (stat_i.rem_zero) state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command and result selection
  always_comb begin
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.emit = EMIT_NONE;
    ctrl_o.idle = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.idle = 1'b1;
        if (in_valid_i) ctrl_o.cmd = CMD_LOAD;
      end
      ST_INSERT: begin
        if (stat_i.too_large) begin
          if (stat_i.out_free) ctrl_o.emit = EMIT_TOO_LARGE;
        end else if (stat_i.need_evict) begin
          if (!stat_i.notify) begin
            ctrl_o.cmd = CMD_EVICT;
          end else if (stat_i.out_free) begin
            ctrl_o.cmd  = CMD_EVICT;
            ctrl_o.emit = EMIT_EVICT;
          end
        end else if (stat_i.out_free) begin
          ctrl_o.cmd  = CMD_APPEND;
          ctrl_o.emit = EMIT_INSERT;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_end) begin
          if (stat_i.out_free) ctrl_o.emit = EMIT_NOT_FOUND;
        end else if (stat_i.scan_match) begin
          if (stat_i.func == FUNC_FIND) begin
            if (stat_i.out_free) ctrl_o.emit = EMIT_FOUND;
          end else if (!stat_i.notify) begin
            ctrl_o.cmd = CMD_DROP;
          end else if (stat_i.out_free) begin
            ctrl_o.cmd  = CMD_DROP;
            ctrl_o.emit = EMIT_REM_EV;
          end
        end else begin
          ctrl_o.cmd = CMD_SCAN_NEXT;
        end
      end
      ST_REM_FIN: begin
        if (stat_i.out_free) ctrl_o.emit = EMIT_REM_FIN;
      end
      ST_REORDER: begin
        if (!stat_i.rem_zero) ctrl_o.cmd = stat_i.hit_now ? CMD_MOVE : CMD_SCAN_NEXT;
      end
      ST_FINAL: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = EMIT_PLAIN;
          if (stat_i.func == FUNC_CLEAR) ctrl_o.cmd = CMD_CLEAR;
        end
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a word is only taken while idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.cmd == CMD_LOAD |-> state_q == ST_IDLE)
    else $error("load outside idle");

  // every emitted result finds a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit != EMIT_NONE |-> stat_i.out_free)
    else $error("emit into busy output");

endmodule

`default_nettype wire

// ===== rtl/core/flbi_datapath.sv =====
// ----------------------------------------------------------------------------
// flbi_datapath
// Entry store, byte and entry accounting, scan and reorder pointers, and the
// result register of the log bucket index.
// ----------------------------------------------------------------------------
`default_nettype none

module flbi_datapath #(
  parameter int unsigned MAX_ENTRIES   = 32,
  parameter int unsigned SLOT_OVERHEAD = 4,
  parameter int unsigned ENTRY_HEADER  = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  flbi_pkg::in_word_t                in_word_i,
  input  wire logic [flbi_pkg::BYTES_W-1:0] bucket_bytes_i,
  input  wire logic                         notify_i,
  input  flbi_pkg::ctrl_t                   ctrl_i,
  input  wire logic                         out_stall_i,
  output flbi_pkg::stat_t                   stat_o,
  output wire logic                         out_valid_o,
  output flbi_pkg::out_word_t               out_word_o
);
  import flbi_pkg::*;

  localparam int unsigned PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [BYTES_W:0] FIXED_COST = (BYTES_W+1)'(ENTRY_HEADER + SLOT_OVERHEAD);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  // entry store, undefined until written
  logic [KEY_W-1:0] ekey_q [MAX_ENTRIES];
  logic [LEN_W-1:0] elen_q [MAX_ENTRIES];

  in_word_t           item_q;
  logic [BYTES_W-1:0] used_q, used_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_q, rem_q, nev_q;
  logic [LEN_W-1:0]   hold_len_q;
  logic [MAX_ENTRIES-1:0] hit_q, hit_load;
  out_word_t          out_q, out_d;
  logic               out_valid_q;

  logic [PW-1:0]      rd_idx, drop_pos, tail_idx, app_idx;
  logic               shift_en;
  logic               move_en;
  logic [BYTES_W:0]   cost_in, cost_drop;
  logic [BYTES_W-1:0] used_dropped, free_now;
  logic               out_free;

  assign rd_idx   = scan_q[PW-1:0];
  assign drop_pos = (ctrl_i.cmd == CMD_EVICT) ? '0 : rd_idx;
  assign tail_idx = PW'(count_q - CNT_W'(1));
  assign app_idx  = count_q[PW-1:0];
  assign move_en  = (ctrl_i.cmd == CMD_MOVE);
  assign shift_en = (ctrl_i.cmd == CMD_EVICT) || (ctrl_i.cmd == CMD_DROP) || move_en;

  // byte cost of the new entry and of the entry being dropped
  assign cost_in   = FIXED_COST + (BYTES_W+1)'(item_q.value_len);
  assign cost_drop = FIXED_COST + (BYTES_W+1)'(elen_q[drop_pos]);
  assign used_dropped = ((BYTES_W+1)'(used_q) >= cost_drop) ?
                        BYTES_W'((BYTES_W+1)'(used_q) - cost_drop) : '0;
  assign free_now = free_of(used_q, bucket_bytes_i);

  // hit flags from the mask, positions past the mask never hit
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_load[i] = (i < MASK_W) ? in_word_i.hit_mask[i % MASK_W] : 1'b0;
    end
  end

  // accounting after this cycle's step
  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    case (ctrl_i.cmd)
      CMD_EVICT, CMD_DROP: begin
        used_d  = used_dropped;
        count_d = count_q - CNT_W'(1);
      end
      CMD_APPEND: begin
        used_d  = BYTES_W'((BYTES_W+1)'(used_q) + cost_in);
        count_d = count_q + CNT_W'(1);
      end
      CMD_CLEAR: begin
        used_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    stat_o.func       = item_q.func;
    stat_o.too_large  = cost_in > (BYTES_W+1)'(bucket_bytes_i);
    stat_o.need_evict = (count_q != '0) &&
                        (((BYTES_W+1)'(free_now) < cost_in) || (count_q >= MAX_CNT));
    stat_o.scan_end   = scan_q >= count_q;
    stat_o.scan_match = ekey_q[rd_idx] == item_q.key;
    stat_o.rem_zero   = rem_q == '0;
    stat_o.hit_now    = hit_q[rd_idx];
    stat_o.out_free   = out_free;
    stat_o.notify     = notify_i;
  end

  // result word, counts reflect the state after the step
  always_comb begin
    out_d             = '0;
    out_d.status      = STAT_OK;
    out_d.free_bytes  = free_of(used_d, bucket_bytes_i);
    out_d.entry_count = count_d;
    out_d.last        = 1'b1;
    case (ctrl_i.emit)
      EMIT_TOO_LARGE: begin
        out_d.status    = STAT_TOO_LARGE;
        out_d.found_len = item_q.value_len;
      end
      EMIT_EVICT: begin
        out_d.is_eviction = 1'b1;
        out_d.key_out     = ekey_q[0];
        out_d.entry_index = nev_q[IDX_W-1:0];
        out_d.found_len   = elen_q[0];
        out_d.last        = 1'b0;
      end
      EMIT_INSERT: begin
        out_d.entry_index = count_q[IDX_W-1:0];
        out_d.found_len   = item_q.value_len;
        out_d.evictions   = nev_q;
      end
      EMIT_NOT_FOUND: out_d.status = STAT_NOT_FOUND;
      EMIT_FOUND: begin
        out_d.entry_index = scan_q[IDX_W-1:0];
        out_d.found_len   = elen_q[rd_idx];
      end
      EMIT_REM_EV: begin
        out_d.is_eviction = 1'b1;
        out_d.key_out     = item_q.key;
        out_d.entry_index = scan_q[IDX_W-1:0];
        out_d.found_len   = elen_q[rd_idx];
        out_d.last        = 1'b0;
      end
      EMIT_REM_FIN: begin
        out_d.entry_index = scan_q[IDX_W-1:0];
        out_d.found_len   = hold_len_q;
      end
      default: ;
    endcase
  end

  // entry store: close the gap, move to tail, append
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
      if (shift_en && (PW'(j) >= drop_pos) && !(move_en && (PW'(j) == tail_idx))) begin
        ekey_q[j] <= ekey_q[j+1];
        elen_q[j] <= elen_q[j+1];
      end
    end
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (move_en && (PW'(j) == tail_idx)) begin
        ekey_q[j] <= ekey_q[rd_idx];
        elen_q[j] <= elen_q[rd_idx];
      end
      if ((ctrl_i.cmd == CMD_APPEND) && (PW'(j) == app_idx)) begin
        ekey_q[j] <= item_q.key;
        elen_q[j] <= item_q.value_len;
      end
    end
  end

  // captured word, removed length and result word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_LOAD) item_q <= in_word_i;
    if (ctrl_i.cmd == CMD_DROP) hold_len_q <= elen_q[rd_idx];
    if (ctrl_i.emit != EMIT_NONE) out_q <= out_d;
  end

  // accounting, pointers and hit flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      rem_q   <= '0;
      nev_q   <= '0;
      hit_q   <= '0;
    end else begin
      used_q  <= used_d;
      count_q <= count_d;
      case (ctrl_i.cmd)
        CMD_LOAD: begin
          scan_q <= '0;
          rem_q  <= count_q;
          nev_q  <= '0;
          hit_q  <= hit_load;
        end
        CMD_EVICT: nev_q <= nev_q + CNT_W'(1);
        CMD_SCAN_NEXT: begin
          scan_q <= scan_q + CNT_W'(1);
          rem_q  <= rem_q - CNT_W'(1);
        end
        CMD_MOVE: begin
          rem_q <= rem_q - CNT_W'(1);
          for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
            if (PW'(j) >= drop_pos) hit_q[j] <= hit_q[j+1];
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit != EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // the list never holds more than its slots
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("entry count over capacity");

  // an append grows the list by one
  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_APPEND |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append lost");

  // eviction only from a non-empty list
  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_EVICT |-> count_q != '0)
    else $error("eviction from empty list");

endmodule

`default_nettype wire

// ===== rtl/core/fifo_log_bucket_index.sv =====
// ----------------------------------------------------------------------------
// fifo_log_bucket_index
// FIFO-evicting index of variable-size entries in one byte-limited bucket:
// insert with oldest-first eviction, find, remove, reorder and clear.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  in        input      in_valid_i / in_stall_o   in_word_i  (in_word_t)
//  out       output     out_valid_o / out_stall_i out_word_o (out_word_t)
//  config    input      APB psel/penable/pwrite   bucket_bytes, notify_enable
//
//  one word at a time: insert evicts oldest entries until the new one fits,
//  find scans from entry 0 to the match, remove does so and then finishes in
//  a final step, a miss and reorder walk every entry in the shifting store
//  no clearing pass after reset; entries are read only below the count
//  results wait in one output register, a stalled output holds the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_log_bucket_index #(
  parameter int unsigned MAX_ENTRIES   = 32,
  parameter int unsigned SLOT_OVERHEAD = 4,
  parameter int unsigned ENTRY_HEADER  = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output wire logic                 in_stall_o,
  input  flbi_pkg::in_word_t        in_word_i,
  output wire logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output flbi_pkg::out_word_t       out_word_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output wire logic                 pready
);
  import flbi_pkg::*;

  logic [BYTES_W-1:0] bucket_q;
  logic               notify_q;
  logic               reg_idx;
  ctrl_t              ctrl;
  stat_t              stat;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q <= BUCKET_RESET;
      notify_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_BUCKET: bucket_q <= pwdata[BYTES_W-1:0];
        REG_NOTIFY: notify_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BUCKET: prdata = 32'(bucket_q);
      REG_NOTIFY: prdata = 32'(notify_q);
      default:    prdata = '0;
    endcase
  end

  assign in_stall_o = !ctrl.idle;

  flbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  flbi_datapath #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .SLOT_OVERHEAD (SLOT_OVERHEAD),
    .ENTRY_HEADER  (ENTRY_HEADER)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_word_i      (in_word_i),
    .bucket_bytes_i (bucket_q),
    .notify_i       (notify_q),
    .ctrl_i         (ctrl),
    .out_stall_i    (out_stall_i),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_word_o     (out_word_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_fifo_log_bucket_index.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_log_bucket_index
// Self-checking bench of the log bucket index: a scoreboard predicts every
// result word from its own copy of the entry list, bucket size and notify
// flag, and checks the words that leave the block in order. Directed words
// cover the field extremes and corner cases, then random phases vary bucket
// size, notify, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fifo_log_bucket_index;
  import flbi_pkg::*;

  localparam int NSLOTS   = 32;
  localparam int HDR_COST = 12 + 4;
  localparam int WD_LIMIT = 5000;

  // scoreboard: list predictor and queue of expected result words
  class bucket_scoreboard;
    logic [63:0] keys[NSLOTS];
    logic [11:0] lens[NSLOTS];
    int          used;
    int          cnt;
    int          bucket;
    bit          notify;
    out_word_t   awaited[$];
    int          n_fail;

    function new();
      used = 0; cnt = 0; bucket = 4084; notify = 1; n_fail = 0;
    endfunction

    function int free_left();
      return (used >= bucket) ? 0 : bucket - used;
    endfunction

    function void push_word(logic [1:0] st, bit ev, logic [63:0] k, int idx,
                            logic [11:0] len, int nev, bit lst);
      out_word_t r;
      r.status      = st;
      r.is_eviction = ev;
      r.key_out     = k;
      r.entry_index = idx[4:0];
      r.found_len   = len;
      r.evictions   = nev[5:0];
      r.free_bytes  = 13'(free_left());
      r.entry_count = cnt[5:0];
      r.last        = lst;
      awaited = {awaited, r};
    endfunction

    function void drop_at(int pos);
      int c;
      c = HDR_COST + lens[pos];
      for (int i = pos; i < cnt - 1; i++) begin
        keys[i] = keys[i+1];
        lens[i] = lens[i+1];
      end
      used = (used >= c) ? used - c : 0;
      cnt--;
    endfunction

    function int find_key(logic [63:0] k);
      for (int i = 0; i < cnt; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    function void note_request(in_word_t w);
      int          cost;
      int          nev;
      int          p;
      int          n;
      logic [63:0] ek;
      logic [11:0] el;
      logic [63:0] nk[NSLOTS];
      logic [11:0] nl[NSLOTS];
      case (w.func)
        FUNC_INSERT: begin
          cost = HDR_COST + w.value_len;
          nev  = 0;
          if (cost > bucket) begin
            push_word(STAT_TOO_LARGE, 0, '0, 0, w.value_len, 0, 1);
          end else begin
            while (cnt > 0 && (free_left() < cost || cnt >= NSLOTS)) begin
              ek = keys[0];
              el = lens[0];
              drop_at(0);
              if (notify) push_word(STAT_OK, 1, ek, nev, el, 0, 0);
              nev++;
            end
            keys[cnt] = w.key;
            lens[cnt] = w.value_len;
            cnt++;
            used += cost;
            push_word(STAT_OK, 0, '0, cnt - 1, w.value_len, nev, 1);
          end
        end
        FUNC_FIND: begin
          p = find_key(w.key);
          if (p < 0) push_word(STAT_NOT_FOUND, 0, '0, 0, '0, 0, 1);
          else push_word(STAT_OK, 0, '0, p, lens[p], 0, 1);
        end
        FUNC_REMOVE: begin
          p = find_key(w.key);
          if (p < 0) begin
            push_word(STAT_NOT_FOUND, 0, '0, 0, '0, 0, 1);
          end else begin
            el = lens[p];
            drop_at(p);
            if (notify) push_word(STAT_OK, 1, w.key, p, el, 0, 0);
            push_word(STAT_OK, 0, '0, p, el, 0, 1);
          end
        end
        FUNC_REORDER: begin
          // misses keep their order at the head, hits follow in order
          n = 0;
          for (int pass = 0; pass < 2; pass++)
            for (int i = 0; i < cnt; i++)
              if (w.hit_mask[i] == pass[0]) begin
                nk[n] = keys[i];
                nl[n] = lens[i];
                n++;
              end
          for (int i = 0; i < n; i++) begin
            keys[i] = nk[i];
            lens[i] = nl[i];
          end
          push_word(STAT_OK, 0, '0, 0, '0, 0, 1);
        end
        FUNC_CLEAR: begin
          used = 0;
          cnt  = 0;
          push_word(STAT_OK, 0, '0, 0, '0, 0, 1);
        end
        default: push_word(STAT_OK, 0, '0, 0, '0, 0, 1);
      endcase
    endfunction

    function void check_reply(out_word_t got);
      out_word_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result word %h", got);
        n_fail++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); n_fail++;
      end
      if (got.is_eviction !== e.is_eviction) begin
        $error("is_eviction: expected %0d, got %0d", e.is_eviction, got.is_eviction);
        n_fail++;
      end
      if (got.key_out !== e.key_out) begin
        $error("key_out: expected %h, got %h", e.key_out, got.key_out); n_fail++;
      end
      if (got.entry_index !== e.entry_index) begin
        $error("entry_index: expected %0d, got %0d", e.entry_index, got.entry_index);
        n_fail++;
      end
      if (got.found_len !== e.found_len) begin
        $error("found_len: expected %0d, got %0d", e.found_len, got.found_len); n_fail++;
      end
      if (got.evictions !== e.evictions) begin
        $error("evictions: expected %0d, got %0d", e.evictions, got.evictions); n_fail++;
      end
      if (got.free_bytes !== e.free_bytes) begin
        $error("free_bytes: expected %0d, got %0d", e.free_bytes, got.free_bytes);
        n_fail++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, got.entry_count);
        n_fail++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); n_fail++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bucket_scoreboard sb = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] key_pool[8];

  fifo_log_bucket_index dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_reply(out_word_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(w);
    @(negedge clk_i);
  endtask

  task automatic send_op(logic [2:0] f, logic [63:0] k, logic [11:0] len,
                         logic [31:0] mask);
    in_word_t w;
    w.func = f; w.key = k; w.value_len = len; w.hit_mask = mask;
    send_word(w);
  endtask

  // wait until every expected word has come back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_bucket(int bytes, bit notify);
    reg_write(3'd4 * REG_BUCKET, 32'(bytes));
    sb.bucket = bytes;
    reg_write(3'd4 * REG_NOTIFY, 32'(notify));
    sb.notify = notify;
  endtask

  task automatic run_random(int n, int len_max, int pause_at);
    in_word_t w;
    int       pick;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        in_valid_i <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(99);
      w.func = (pick < 42) ? FUNC_INSERT : (pick < 62) ? FUNC_FIND :
               (pick < 78) ? FUNC_REMOVE : (pick < 90) ? FUNC_REORDER :
               (pick < 95) ? FUNC_CLEAR : 3'($urandom_range(7, 5));
      w.key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)]
                                      : {$urandom, $urandom};
      w.value_len = ($urandom_range(9) == 0) ? 12'($urandom)
                                             : 12'($urandom_range(len_max));
      w.hit_mask = $urandom;
      send_word(w);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, eviction, too large, misses, reorder, clear, bad codes
    set_bucket(4084, 1'b1);
    send_op(FUNC_INSERT, 64'h1, 12'd0, '0);
    send_op(FUNC_INSERT, 64'h2, 12'd4095, '0);
    send_op(FUNC_INSERT, '1, 12'd4000, '1);
    send_op(FUNC_INSERT, '0, 12'd100, '0);
    send_op(FUNC_FIND, '0, '0, '0);
    send_op(FUNC_FIND, 64'h1, '0, '0);
    send_op(FUNC_INSERT, 64'h3, 12'd50, '0);
    send_op(FUNC_INSERT, 64'h4, 12'd7, '0);
    send_op(FUNC_REORDER, '0, '0, 32'h1);
    send_op(FUNC_REORDER, '0, '0, '1);
    send_op(FUNC_REORDER, '0, '0, '0);
    send_op(FUNC_REORDER, '0, '0, 32'hAAAA_AAAA);
    send_op(FUNC_FIND, 64'h4, '0, '0);
    send_op(FUNC_REMOVE, 64'h3, '0, '0);
    send_op(FUNC_REMOVE, 64'h1, '0, '0);
    send_op(3'd5, '1, '1, '1);
    send_op(3'd6, '0, '0, '0);
    send_op(3'd7, 64'h5555_5555_5555_5555, 12'hAAA, 32'h5555_5555);
    send_op(FUNC_CLEAR, '0, '0, '0);
    send_op(FUNC_FIND, '0, '0, '0);
    drain();

    // random phases
    set_bucket(4096, 1'b1);
    run_random(20, 300, -1);
    drain();
    idle_pct = 50; stall_pct = 0;
    set_bucket(64, 1'b1);
    run_random(20, 40, -1);
    drain();
    idle_pct = 0; stall_pct = 50;
    set_bucket(1000, 1'b0);
    run_random(20, 20, -1);
    drain();
    idle_pct = 12; stall_pct = 12;
    set_bucket(300, 1'b1);
    run_random(20, 60, 12);
    drain();

    if (sb.n_fail == 0 && sb.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/flbi_pkg.sv
rtl/core/flbi_ctrl.sv
rtl/core/flbi_datapath.sv
rtl/core/fifo_log_bucket_index.sv
verif/tb_fifo_log_bucket_index.sv
